// ----- src/tsc_pkg.sv -----
// Shared types, character constants and the byte classifier for the text statistics counter.
package tsc_pkg;

   // Fixed alphabet: one histogram bin for each byte value.
   localparam int ALPHABET_SIZE = 256;
   localparam int BYTE_BITS     = 8;
   localparam int OUT_BITS      = 16;
   localparam int CLASS_COUNT   = 8;

   // Packed report width: ten 16-bit totals and the peak byte.
   localparam int RSP_BITS = 10 * OUT_BITS + BYTE_BITS;

   // Indexes into the class counter bank.
   localparam int K_VOWEL = 0;
   localparam int K_CONS  = 1;
   localparam int K_DIGIT = 2;
   localparam int K_SPACE = 3;
   localparam int K_PUNCT = 4;
   localparam int K_SENT  = 5;
   localparam int K_PARA  = 6;
   localparam int K_WORD  = 7;

   // Character constants.
   localparam logic [BYTE_BITS-1:0] CH_A_LOW  = 8'h61;
   localparam logic [BYTE_BITS-1:0] CH_E_LOW  = 8'h65;
   localparam logic [BYTE_BITS-1:0] CH_I_LOW  = 8'h69;
   localparam logic [BYTE_BITS-1:0] CH_O_LOW  = 8'h6F;
   localparam logic [BYTE_BITS-1:0] CH_U_LOW  = 8'h75;
   localparam logic [BYTE_BITS-1:0] CH_Z_LOW  = 8'h7A;
   localparam logic [BYTE_BITS-1:0] CH_A_UP   = 8'h41;
   localparam logic [BYTE_BITS-1:0] CH_Z_UP   = 8'h5A;
   localparam logic [BYTE_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [BYTE_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_BITS-1:0] CH_BANG   = 8'h21;
   localparam logic [BYTE_BITS-1:0] CH_TILDE  = 8'h7E;
   localparam logic [BYTE_BITS-1:0] CH_PERIOD = 8'h2E;
   localparam logic [BYTE_BITS-1:0] CH_QUERY  = 8'h3F;
   localparam logic [BYTE_BITS-1:0] CASE_BIT  = 8'h20;

   // Class flags of one byte; several may be set together.
   typedef struct packed {
      logic vowel;
      logic cons;
      logic digit;
      logic space;
      logic punct;
      logic sent;
      logic para;
      logic alnum;
   } cls_type;

   // C-locale classification of one byte.
   function automatic cls_type classify(input logic [BYTE_BITS-1:0] c);
      cls_type                r;
      logic [BYTE_BITS-1:0]   low;
      logic                   alpha;
      logic                   digit;
      logic                   space;
      logic                   vowel;
      low   = c | CASE_BIT;
      alpha = ((c >= CH_A_UP) && (c <= CH_Z_UP)) || ((c >= CH_A_LOW) && (c <= CH_Z_LOW));
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      vowel = (low == CH_A_LOW) || (low == CH_E_LOW) || (low == CH_I_LOW) ||
              (low == CH_O_LOW) || (low == CH_U_LOW);
      r       = '0;
      r.vowel = alpha && vowel;
      r.cons  = alpha && !vowel;
      r.digit = digit;
      r.space = space;
      r.para  = (c == CH_LF) || (c == CH_CR);
      r.punct = !alpha && !digit && (c >= CH_BANG) && (c <= CH_TILDE);
      r.sent  = (c == CH_PERIOD) || (c == CH_BANG) || (c == CH_QUERY);
      r.alnum = alpha || digit;
      return r;
   endfunction

endpackage

// ----- src/text_statistics_counter_top.sv -----
// Text statistics counter: byte histogram in a synchronous memory, class and word totals.
// The report beat is registered on rsp when the final text byte leaves the update stage.
// Throughput: one byte per cycle; the histogram read-modify-write has a two-stage loop
// (memory read, then update and write) closed by forwarding the previous write.
// A byte with tlast waits in the update stage only while an earlier report beat is not taken.
// Reset clears control state; per-bin valid flip-flops mark every bin empty.
module text_statistics_counter_top
   import tsc_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // Input stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] text_byte
   input  logic                 req_tlast,   // end_of_text
   // Report stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_BITS-1:0]  rsp_tdata    // [15:0] total_length, [31:16] words,
                                             // [47:32] sentences, [63:48] paragraphs,
                                             // [79:64] vowels, [95:80] consonants,
                                             // [111:96] digits, [127:112] whitespace,
                                             // [143:128] punctuation, [159:144] peak_count,
                                             // [167:160] peak_byte
);

   localparam int ADDR_BITS = $clog2(ALPHABET_SIZE);

   // Saturating increment of a counter.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
   endfunction

   // Clamp a counter to the 16-bit report field.
   function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
   endfunction

   // Histogram memory and its per-bin valid bits
   logic [COUNT_BITS-1:0]    hist_mem [ALPHABET_SIZE];
   logic [COUNT_BITS-1:0]    rd_data_ff;
   logic [ALPHABET_SIZE-1:0] hist_vld_ff, hist_vld_in;

   // Update stage
   logic                     s1_valid_ff, s1_valid_in;
   logic [ADDR_BITS-1:0]     s1_byte_ff;
   logic                     s1_last_ff;

   // Last histogram write, for forwarding
   logic                     fwd_en_ff, fwd_en_in;
   logic [ADDR_BITS-1:0]     fwd_addr_ff;
   logic [COUNT_BITS-1:0]    fwd_data_ff;

   // Running totals
   logic [COUNT_BITS-1:0]    byte_total_ff, byte_total_in;
   logic [COUNT_BITS-1:0]    cls_cnt_ff [CLASS_COUNT];
   logic [COUNT_BITS-1:0]    cls_cnt_in [CLASS_COUNT];
   logic                     inside_word_ff, inside_word_in;
   logic [COUNT_BITS-1:0]    best_count_ff, best_count_in;
   logic [ADDR_BITS-1:0]     best_byte_ff, best_byte_in;

   // Report register
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_BITS-1:0]      rsp_tdata_ff, rsp_tdata_in;

   logic                     req_accept;
   logic                     s1_adv;
   logic                     s1_report;
   logic                     hist_wr;
   logic                     fwd_hit;
   logic [COUNT_BITS-1:0]    bin_old;
   logic [COUNT_BITS-1:0]    bin_new;
   cls_type                  cls;

   // Handshake: the update stage moves on unless a report would overwrite one not yet taken
   assign s1_adv     = s1_valid_ff && (!s1_last_ff || !rsp_tvalid_ff || rsp_tready);
   assign s1_report  = s1_adv && s1_last_ff;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Histogram memory: read on accept, write back from the update stage
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= hist_mem[req_tdata[ADDR_BITS-1:0]];
      end
      if (hist_wr) begin
         hist_mem[s1_byte_ff] <= bin_new;
      end
   end

   // Bin read with forwarding of the write made at the read's own edge
   assign fwd_hit = fwd_en_ff && (fwd_addr_ff == s1_byte_ff);
   always_comb begin
      if (fwd_hit) begin
         bin_old = fwd_data_ff;
      end else if (hist_vld_ff[s1_byte_ff]) begin
         bin_old = rd_data_ff;
      end else begin
         bin_old = '0;
      end
      bin_new = sat_inc(bin_old);
   end

   // The final byte's bin is discarded with the rest, so it is not written
   assign hist_wr   = s1_adv && !s1_last_ff;
   assign fwd_en_in = hist_wr ? 1'b1 : (s1_report ? 1'b0 : fwd_en_ff);

   // Valid bits: set on write, all cleared after a report
   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (s1_report) begin
         hist_vld_in = '0;
      end else if (hist_wr) begin
         hist_vld_in[s1_byte_ff] = 1'b1;
      end
   end

   // Classification and next totals of the update stage
   assign cls = classify(BYTE_BITS'(s1_byte_ff));

   always_comb begin
      byte_total_in  = byte_total_ff;
      inside_word_in = inside_word_ff;
      best_count_in  = best_count_ff;
      best_byte_in   = best_byte_ff;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         cls_cnt_in[k] = cls_cnt_ff[k];
      end
      if (s1_adv) begin
         byte_total_in = sat_inc(byte_total_ff);
         if (bin_new > best_count_ff) begin
            best_count_in = bin_new;
            best_byte_in  = s1_byte_ff;
         end
         if (cls.vowel) cls_cnt_in[K_VOWEL] = sat_inc(cls_cnt_ff[K_VOWEL]);
         if (cls.cons)  cls_cnt_in[K_CONS]  = sat_inc(cls_cnt_ff[K_CONS]);
         if (cls.digit) cls_cnt_in[K_DIGIT] = sat_inc(cls_cnt_ff[K_DIGIT]);
         if (cls.space) cls_cnt_in[K_SPACE] = sat_inc(cls_cnt_ff[K_SPACE]);
         if (cls.punct) cls_cnt_in[K_PUNCT] = sat_inc(cls_cnt_ff[K_PUNCT]);
         if (cls.sent)  cls_cnt_in[K_SENT]  = sat_inc(cls_cnt_ff[K_SENT]);
         if (cls.para)  cls_cnt_in[K_PARA]  = sat_inc(cls_cnt_ff[K_PARA]);
         if (cls.alnum && !inside_word_ff) begin
            cls_cnt_in[K_WORD] = sat_inc(cls_cnt_ff[K_WORD]);
         end
         inside_word_in = cls.alnum;
      end
   end

   // Report beat built from the totals including the final byte
   assign rsp_tdata_in = {BYTE_BITS'(best_byte_in),
                          sat_out(best_count_in),
                          sat_out(cls_cnt_in[K_PUNCT]),
                          sat_out(cls_cnt_in[K_SPACE]),
                          sat_out(cls_cnt_in[K_DIGIT]),
                          sat_out(cls_cnt_in[K_CONS]),
                          sat_out(cls_cnt_in[K_VOWEL]),
                          sat_out(cls_cnt_in[K_PARA]),
                          sat_out(cls_cnt_in[K_SENT]),
                          sat_out(cls_cnt_in[K_WORD]),
                          sat_out(byte_total_in)};

   always_comb begin
      if (s1_report) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   // Control and total registers; a report returns every total to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         fwd_en_ff      <= 1'b0;
         hist_vld_ff    <= '0;
         rsp_tvalid_ff  <= 1'b0;
         byte_total_ff  <= '0;
         inside_word_ff <= 1'b0;
         best_count_ff  <= '0;
         best_byte_ff   <= '0;
         for (int k = 0; k < CLASS_COUNT; k++) begin
            cls_cnt_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_en_ff     <= fwd_en_in;
         hist_vld_ff   <= hist_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (s1_report) begin
            byte_total_ff  <= '0;
            inside_word_ff <= 1'b0;
            best_count_ff  <= '0;
            best_byte_ff   <= '0;
            for (int k = 0; k < CLASS_COUNT; k++) begin
               cls_cnt_ff[k] <= '0;
            end
         end else begin
            byte_total_ff  <= byte_total_in;
            inside_word_ff <= inside_word_in;
            best_count_ff  <= best_count_in;
            best_byte_ff   <= best_byte_in;
            for (int k = 0; k < CLASS_COUNT; k++) begin
               cls_cnt_ff[k] <= cls_cnt_in[k];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_tdata[ADDR_BITS-1:0];
         s1_last_ff <= req_tlast;
      end
      if (hist_wr) begin
         fwd_addr_ff <= s1_byte_ff;
         fwd_data_ff <= bin_new;
      end
      if (s1_report) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // A report leaves every histogram bin empty
   a_clear_after_report: assert property (@(posedge clock) disable iff (reset)
      s1_report |=> (hist_vld_ff == '0) && !fwd_en_ff)
      else $error("histogram not cleared after report");

   // A forwarded bin always belongs to a bin already marked valid
   a_fwd_valid: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && fwd_hit) |-> hist_vld_ff[s1_byte_ff])
      else $error("forwarded bin not marked valid");

   // The peak bin never exceeds the byte total
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      best_count_ff <= byte_total_ff)
      else $error("peak count above byte total");

   // A stalled update stage keeps its byte
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff))
      else $error("update stage lost its byte during a stall");

endmodule
